@@ rtl/nnfs_pkg.sv @@
// Shared types and constants of the nearest-neighbor frame scaler.
`timescale 1ns / 1ps
package nnfs_pkg;

  // Size limits
  localparam int MAX_SRC_WIDTH  = 512;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_DST_SIZE   = 4095;

  // 16.16 fixed point
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 32;

  // Register and field widths
  localparam int SW_W       = 10;
  localparam int SH_W       = 9;
  localparam int DW_W       = 12;
  localparam int CNT_W      = 12;
  localparam int CFG_DATA_W = 12;
  localparam int PIX_W      = 32;

  // Frame store geometry
  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LIMIT_W     = ADDR_W + 1;
  localparam int COL_W       = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_W       = $clog2(MAX_SRC_HEIGHT);

  // Step divider
  localparam int DIVIDEND_W = SW_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // Reset register values and the steps they give
  localparam logic [SW_W-1:0] RST_SRC_WIDTH  = SW_W'(320);
  localparam logic [SH_W-1:0] RST_SRC_HEIGHT = SH_W'(200);
  localparam logic [DW_W-1:0] RST_DST_WIDTH  = DW_W'(640);
  localparam logic [DW_W-1:0] RST_DST_HEIGHT = DW_W'(400);
  localparam logic [ACC_W-1:0] RST_COL_STEP  = ACC_W'((320 * 65536) / 640 + 1);
  localparam logic [ACC_W-1:0] RST_ROW_STEP  = ACC_W'((200 * 65536) / 400 + 1);

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH,
    CFG_SRC_HEIGHT,
    CFG_DST_WIDTH,
    CFG_DST_HEIGHT
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD,
    OP_EMIT
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  typedef struct packed {
    op_t              operation;
    logic [PIX_W-1:0] source_pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } out_t;

endpackage

@@ rtl/nnfs_div.sv @@
// Radix-2 restoring divider that forms one scale step quotient, one bit per cycle.
`timescale 1ns / 1ps
module nnfs_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [nnfs_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [nnfs_pkg::DW_W-1:0]       divisor,
  output logic                            done,
  output logic [nnfs_pkg::DIVIDEND_W-1:0] quotient
);
  import nnfs_pkg::*;

  logic [DW_W-1:0]       rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DW_W-1:0]       dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  done_r;

  logic [DW_W:0] shifted;
  logic [DW_W:0] diff;
  logic          fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    shifted = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
  end

  // Count iterations and flag the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        cnt_r <= DIV_CNT_W'(DIVIDEND_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  // Load operands, then retire one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[DW_W-1:0] : shifted[DW_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/nearest_neighbor_frame_scaler_unit.sv @@
// Top level of the nearest-neighbor frame scaler: frame store, raster counters and control.
// A load transfer gives no result; loads may follow every cycle while busy is low.
// An emit transfer gives its result strobe in the cycle after it is taken; emits may follow
// every cycle while busy is low. An emit that opens a frame after a register write holds
// busy while the two step dividers run, one quotient bit per cycle.
// Synchronous reset clears control state; frame store contents stay undefined until loaded.
`timescale 1ns / 1ps
module nearest_neighbor_frame_scaler_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  nnfs_pkg::in_t                   in_data,
  output logic                            out_valid,
  output nnfs_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  nnfs_pkg::cfg_idx_t              cfg_index,
  input  logic [nnfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nnfs_pkg::*;

  // Configuration registers
  logic [SW_W-1:0] src_width_r;
  logic [SH_W-1:0] src_height_r;
  logic [DW_W-1:0] dst_width_r;
  logic [DW_W-1:0] dst_height_r;

  // Control state
  state_t           state_r, state_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [ACC_W-1:0] col_acc_r, col_acc_nxt;
  logic [ACC_W-1:0] row_acc_r, row_acc_nxt;
  logic [ACC_W-1:0] col_step_r, col_step_nxt;
  logic [ACC_W-1:0] row_step_r, row_step_nxt;
  logic             dirty_r, dirty_nxt;
  logic             pend_col_r, pend_col_nxt;
  logic             pend_row_r, pend_row_nxt;
  logic             out_valid_r;
  logic             row_end_r;
  logic             frame_end_r;

  // Frame store
  logic [PIX_W-1:0] mem [STORE_DEPTH];
  logic [PIX_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] mem_addr;
  logic             mem_we;

  // Clamped sizes
  logic [SW_W-1:0] sw, sw_m1;
  logic [SH_W-1:0] sh, sh_m1;
  logic [DW_W-1:0] dw, dh;
  logic [LIMIT_W-1:0] limit;

  // Transfer decode
  logic accept, load_acc, emit_acc;

  // Load path
  logic [ADDR_W-1:0]  wr_pos;
  logic [LIMIT_W-1:0] wr_pos_inc;

  // Emit path
  logic             frame_start, need_div;
  logic [ACC_W-1:0] cacc, racc;
  logic [ACC_W-FRAC_BITS-1:0] col_raw, row_raw;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [LIMIT_W-1:0] rd_sum;
  logic             row_end, frame_end;

  // Dividers
  logic                  div_start;
  logic                  col_done, row_done, div_done;
  logic [DIVIDEND_W-1:0] col_quo, row_quo;

  // Clamp sizes into their legal ranges
  always_comb begin
    priority if (src_width_r == '0) sw = SW_W'(1);
    else if (src_width_r > SW_W'(MAX_SRC_WIDTH)) sw = SW_W'(MAX_SRC_WIDTH);
    else sw = src_width_r;
    priority if (src_height_r == '0) sh = SH_W'(1);
    else if (src_height_r > SH_W'(MAX_SRC_HEIGHT)) sh = SH_W'(MAX_SRC_HEIGHT);
    else sh = src_height_r;
    priority if (dst_width_r == '0) dw = DW_W'(1);
    else if (dst_width_r > DW_W'(MAX_DST_SIZE)) dw = DW_W'(MAX_DST_SIZE);
    else dw = dst_width_r;
    priority if (dst_height_r == '0) dh = DW_W'(1);
    else if (dst_height_r > DW_W'(MAX_DST_SIZE)) dh = DW_W'(MAX_DST_SIZE);
    else dh = dst_height_r;
    sw_m1 = sw - SW_W'(1);
    sh_m1 = sh - SH_W'(1);
    limit = LIMIT_W'(sw) * LIMIT_W'(sh);
  end

  // Busy while the step dividers run
  assign busy     = (state_r == ST_DIV);
  assign accept   = start && !busy;
  assign load_acc = accept && (in_data.operation == OP_LOAD);
  assign emit_acc = accept && (in_data.operation == OP_EMIT);

  // Load position, wrapped at the source frame size
  always_comb begin
    wr_pos     = ({1'b0, wp_r} >= limit) ? '0 : wp_r;
    wr_pos_inc = {1'b0, wr_pos} + LIMIT_W'(1);
  end

  // Source index and raster flags of the next emit
  always_comb begin
    frame_start = (col_cnt_r == '0) && (row_cnt_r == '0);
    need_div    = frame_start && dirty_r;
    cacc        = frame_start ? '0 : col_acc_r;
    racc        = frame_start ? '0 : row_acc_r;
    col_raw     = cacc[ACC_W-1:FRAC_BITS];
    row_raw     = racc[ACC_W-1:FRAC_BITS];
    col = (col_raw > (ACC_W-FRAC_BITS)'(sw_m1)) ? sw_m1[COL_W-1:0] : col_raw[COL_W-1:0];
    row = (row_raw > (ACC_W-FRAC_BITS)'(sh_m1)) ? sh_m1[ROW_W-1:0] : row_raw[ROW_W-1:0];
    rd_sum      = LIMIT_W'(row) * LIMIT_W'(sw) + LIMIT_W'(col);
    row_end     = (col_cnt_r >= (dw - DW_W'(1)));
    frame_end   = row_end && (row_cnt_r >= (dh - DW_W'(1)));
    mem_we      = load_acc;
    mem_addr    = load_acc ? wr_pos : rd_sum[ADDR_W-1:0];
  end

  // Next state of counters, accumulators, steps and the control FSM
  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    col_acc_nxt  = col_acc_r;
    row_acc_nxt  = row_acc_r;
    col_step_nxt = col_step_r;
    row_step_nxt = row_step_r;
    dirty_nxt    = dirty_r || cfg_we;
    pend_col_nxt = pend_col_r;
    pend_row_nxt = pend_row_r;
    div_start    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (load_acc) begin
          wp_nxt = (wr_pos_inc >= limit) ? '0 : wr_pos_inc[ADDR_W-1:0];
        end
        if (emit_acc) begin
          // advance raster position; defer the step add when steps are stale
          if (row_end) begin
            col_cnt_nxt = '0;
            col_acc_nxt = '0;
            if (frame_end) begin
              row_cnt_nxt = '0;
              row_acc_nxt = '0;
            end else begin
              row_cnt_nxt = row_cnt_r + CNT_W'(1);
              row_acc_nxt = need_div ? racc : racc + row_step_r;
            end
          end else begin
            col_cnt_nxt = col_cnt_r + CNT_W'(1);
            col_acc_nxt = need_div ? cacc : cacc + col_step_r;
            row_acc_nxt = racc;
          end
          if (need_div) begin
            pend_col_nxt = !row_end;
            pend_row_nxt = row_end && !frame_end;
            div_start    = 1'b1;
            state_nxt    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // install fresh steps and apply the deferred add
          col_step_nxt = ACC_W'(col_quo) + ACC_W'(1);
          row_step_nxt = ACC_W'(row_quo) + ACC_W'(1);
          if (pend_col_r) col_acc_nxt = col_acc_r + col_step_nxt;
          if (pend_row_r) row_acc_nxt = row_acc_r + row_step_nxt;
          dirty_nxt = cfg_we;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      col_acc_r   <= '0;
      row_acc_r   <= '0;
      col_step_r  <= RST_COL_STEP;
      row_step_r  <= RST_ROW_STEP;
      dirty_r     <= 1'b0;
      pend_col_r  <= 1'b0;
      pend_row_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_acc_r   <= col_acc_nxt;
      row_acc_r   <= row_acc_nxt;
      col_step_r  <= col_step_nxt;
      row_step_r  <= row_step_nxt;
      dirty_r     <= dirty_nxt;
      pend_col_r  <= pend_col_nxt;
      pend_row_r  <= pend_row_nxt;
      out_valid_r <= emit_acc;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SRC_WIDTH;
      src_height_r <= RST_SRC_HEIGHT;
      dst_width_r  <= RST_DST_WIDTH;
      dst_height_r <= RST_DST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SW_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[SH_W-1:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_data[DW_W-1:0];
        CFG_DST_HEIGHT: dst_height_r <= cfg_data[DW_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_data.source_pixel;
    end
    rd_data_r <= mem[mem_addr];
  end

  // Hold raster flags alongside the read
  always_ff @(posedge clk) begin
    if (emit_acc) begin
      row_end_r   <= row_end;
      frame_end_r <= frame_end;
    end
  end

  // Step dividers: (size << 16) / dest_size
  nnfs_div u_col_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sw, FRAC_BITS'(0)}),
    .divisor  (dw),
    .done     (col_done),
    .quotient (col_quo)
  );

  nnfs_div u_row_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIVIDEND_W'({sh, FRAC_BITS'(0)})),
    .divisor  (dh),
    .done     (row_done),
    .quotient (row_quo)
  );

  assign div_done = col_done && row_done;

  assign out_valid          = out_valid_r;
  assign out_data.pixel     = rd_data_r;
  assign out_data.row_end   = row_end_r;
  assign out_data.frame_end = frame_end_r;

endmodule

@@ rtl/nnfs_chk.sv @@
// Port-level checker for the frame scaler, bound to the top level.
`timescale 1ns / 1ps
module nnfs_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input nnfs_pkg::in_t  in_data,
  input logic           out_valid,
  input nnfs_pkg::out_t out_data
);
  import nnfs_pkg::*;

  // Every accepted emit gives a result strobe in the next cycle
  a_emit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.operation == OP_EMIT) |=> out_valid)
    else $error("emit transfer without result");

  // No result strobe without an accepted emit in the previous cycle
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_data.operation == OP_EMIT))
    else $error("result without emit transfer");

  // Frame end only on the last pixel of a row
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.frame_end) |-> out_data.row_end)
    else $error("frame end without row end");

  // Busy rises only after an accepted emit
  a_busy_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_data.operation == OP_EMIT))
    else $error("busy without emit transfer");

endmodule

bind nearest_neighbor_frame_scaler_unit nnfs_chk u_nnfs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
